// File: rtl/aip_pkg.sv
// Shared types, constants and helper functions of the ASCII integer parser.
`default_nettype none

package aip_pkg;

  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned CNT_W      = 8;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = 8'd255;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RADIX_HINT   = 2'd0;
  localparam logic [1:0] CFG_SIGN_ALLOWED = 2'd1;
  localparam logic [1:0] CFG_MAX_CHARS    = 2'd2;

  // Radix constants.
  localparam logic [5:0] RADIX_AUTO = 6'd0;
  localparam logic [5:0] RADIX_ONE  = 6'd1;
  localparam logic [5:0] RADIX_OCT  = 6'd8;
  localparam logic [5:0] RADIX_DEC  = 6'd10;
  localparam logic [5:0] RADIX_HEX  = 6'd16;
  localparam logic [5:0] RADIX_MAX  = 6'd36;

  // Character codes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_MORE       = 3'd0,
    ST_DONE_CHAR  = 3'd1,
    ST_DONE_WIDTH = 3'd2,
    ST_FAIL       = 3'd3,
    ST_IDLE       = 3'd4
  } aip_status_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_START  = 3'd1,
    PH_PREFIX = 3'd2,
    PH_HELD   = 3'd3,
    PH_DIGITS = 3'd4
  } aip_phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
  } aip_in_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [VALUE_BITS-1:0] value;
    logic                  negative;
    logic [CNT_W-1:0]      consumed;
  } aip_out_t;

  typedef struct packed {
    logic [5:0] radix_hint;
    logic       sign_allowed;
    logic [7:0] max_chars;
  } aip_cfg_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] acc;
    logic                  minus;
    logic [CNT_W-1:0]      cnt;
    aip_phase_e            phase;
    logic [5:0]            radix;
    logic                  digit_seen;
  } aip_state_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } aip_digit_t;

  function automatic aip_digit_t char_digit(logic [7:0] c);
    aip_digit_t d;
    d.ok  = 1'b0;
    d.val = 6'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.ok  = 1'b1;
      d.val = 6'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d.ok  = 1'b1;
      d.val = 6'(c - CH_LO_A) + 6'd10;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d.ok  = 1'b1;
      d.val = 6'(c - CH_UP_A) + 6'd10;
    end
    return d;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] cnt);
    return (cnt == COUNT_LIMIT) ? cnt : cnt + 1'b1;
  endfunction

  function automatic logic width_hit(logic [CNT_W-1:0] cnt, logic [7:0] max_chars);
    return (max_chars != 8'd0) && (cnt >= max_chars);
  endfunction

  function automatic logic two_left(logic [CNT_W-1:0] cnt, logic [7:0] max_chars);
    return (max_chars == 8'd0) || (({1'b0, cnt} + 9'd2) <= {1'b0, max_chars});
  endfunction

endpackage

`default_nettype wire

// File: rtl/aip_step.sv
// One parser step: next state and status from the current state and one character.
`default_nettype none

module aip_step (
  input  aip_pkg::aip_state_t  state_i,
  input  aip_pkg::aip_cfg_t    cfg_i,
  input  aip_pkg::aip_in_t     item_i,
  output aip_pkg::aip_state_t  state_o,
  output aip_pkg::aip_status_e status_o
);

  aip_pkg::aip_state_t  st;
  aip_pkg::aip_status_e status;
  aip_pkg::aip_digit_t  dig;
  logic                 do_prefix;
  logic                 do_digit;
  logic                 fail;
  logic [7:0]           c;
  logic [5:0]           r;
  logic [69:0]          prod;

  always_comb begin
    st        = state_i;
    status    = aip_pkg::ST_MORE;
    do_prefix = 1'b0;
    do_digit  = 1'b0;
    fail      = 1'b0;
    c         = item_i.ch;
    r         = cfg_i.radix_hint;
    dig       = aip_pkg::char_digit(c);
    prod      = '0;

    if (item_i.start_req) begin
      st.acc        = '0;
      st.minus      = 1'b0;
      st.cnt        = '0;
      st.radix      = '0;
      st.digit_seen = 1'b0;
      st.phase      = aip_pkg::PH_START;
    end

    case (st.phase)
      aip_pkg::PH_START: begin
        if (r == aip_pkg::RADIX_ONE || r > aip_pkg::RADIX_MAX) begin
          fail = 1'b1;
        end else if (cfg_i.sign_allowed && (c == aip_pkg::CH_PLUS || c == aip_pkg::CH_MINUS)) begin
          st.minus = (c == aip_pkg::CH_MINUS);
          st.cnt   = aip_pkg::sat_inc(st.cnt);
          if (aip_pkg::width_hit(st.cnt, cfg_i.max_chars)) begin
            fail = 1'b1;
          end else begin
            st.phase = aip_pkg::PH_PREFIX;
          end
        end else begin
          do_prefix = 1'b1;
        end
      end
      aip_pkg::PH_PREFIX: begin
        do_prefix = 1'b1;
      end
      aip_pkg::PH_HELD: begin
        if (c == aip_pkg::CH_LO_X || c == aip_pkg::CH_UP_X) begin
          st.cnt   = aip_pkg::sat_inc(st.cnt);
          st.radix = aip_pkg::RADIX_HEX;
          if (aip_pkg::width_hit(st.cnt, cfg_i.max_chars)) begin
            fail = 1'b1;
          end else begin
            st.phase = aip_pkg::PH_DIGITS;
          end
        end else begin
          // The held zero becomes the first digit of the number.
          st.acc        = '0;
          st.digit_seen = 1'b1;
          st.phase      = aip_pkg::PH_DIGITS;
          do_digit      = 1'b1;
        end
      end
      aip_pkg::PH_DIGITS: begin
        do_digit = 1'b1;
      end
      default: begin
        status   = aip_pkg::ST_IDLE;
        st.phase = aip_pkg::PH_IDLE;
      end
    endcase

    if (do_prefix) begin
      if ((r == aip_pkg::RADIX_AUTO || r == aip_pkg::RADIX_HEX) && c == aip_pkg::CH_ZERO &&
          aip_pkg::two_left(st.cnt, cfg_i.max_chars)) begin
        st.cnt   = aip_pkg::sat_inc(st.cnt);
        st.radix = (r == aip_pkg::RADIX_AUTO) ? aip_pkg::RADIX_OCT : aip_pkg::RADIX_HEX;
        st.phase = aip_pkg::PH_HELD;
      end else begin
        if (r == aip_pkg::RADIX_AUTO) begin
          st.radix = (c == aip_pkg::CH_ZERO) ? aip_pkg::RADIX_OCT : aip_pkg::RADIX_DEC;
        end else begin
          st.radix = r;
        end
        st.phase = aip_pkg::PH_DIGITS;
        do_digit = 1'b1;
      end
    end

    if (do_digit) begin
      if (dig.ok && dig.val < st.radix) begin
        prod          = {6'd0, st.acc} * {64'd0, st.radix};
        st.acc        = prod[aip_pkg::VALUE_BITS-1:0] + {58'd0, dig.val};
        st.digit_seen = 1'b1;
        st.cnt        = aip_pkg::sat_inc(st.cnt);
        if (aip_pkg::width_hit(st.cnt, cfg_i.max_chars)) begin
          st.phase = aip_pkg::PH_IDLE;
          status   = aip_pkg::ST_DONE_WIDTH;
        end
      end else if (st.digit_seen) begin
        st.phase = aip_pkg::PH_IDLE;
        status   = aip_pkg::ST_DONE_CHAR;
      end else begin
        fail = 1'b1;
      end
    end

    if (fail) begin
      st.acc        = '0;
      st.minus      = 1'b0;
      st.cnt        = '0;
      st.digit_seen = 1'b0;
      st.phase      = aip_pkg::PH_IDLE;
      status        = aip_pkg::ST_FAIL;
    end

    state_o  = st;
    status_o = status;
  end

endmodule

`default_nettype wire

// File: rtl/ascii_integer_parser.sv
// Top level of the ASCII integer parser: input register, parser step and result register.
//
// Characters arrive one beat each on the in channel (in_valid_i / in_ready_o); a beat with
// start_req set begins a new number. Every input beat yields exactly one result beat on the
// out channel (out_valid_o / out_ready_i) with the status, the accumulated value, the sign
// and the consumed count after that character.
// A beat is captured in the input register; the parser step runs combinationally between
// that register and the result register, which takes the result when it is empty or being
// drained. One character is processed per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its beat and the input register holds
// the next one; in_ready_o drops only when both are full, and the flow resumes at full rate.
// Configuration writes (cfg_valid_i / cfg_ready_o) are always accepted; index 0
// is the radix hint, 1 the sign enable, 2 the width limit, other indexes are ignored.
// Reset clears both registers' valid flags, returns the parser to idle and loads the
// configuration defaults: radix 10, signs allowed, no width limit.
`default_nettype none

module ascii_integer_parser (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  aip_pkg::aip_in_t      in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output aip_pkg::aip_out_t     out_data_o,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire  [1:0]            cfg_index_i,
  input  wire  [7:0]            cfg_data_i
);

  aip_pkg::aip_cfg_t    cfg_q;
  aip_pkg::aip_state_t  state_q;
  aip_pkg::aip_state_t  state_d;
  aip_pkg::aip_status_e status_d;
  aip_pkg::aip_in_t     in_q;
  logic                 in_vld_q;
  aip_pkg::aip_out_t    out_q;
  logic                 out_vld_q;
  logic                 advance;

  assign advance     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  aip_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .status_o (status_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radix_hint   <= aip_pkg::RADIX_DEC;
      cfg_q.sign_allowed <= 1'b1;
      cfg_q.max_chars    <= 8'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        aip_pkg::CFG_RADIX_HINT:   cfg_q.radix_hint   <= cfg_data_i[5:0];
        aip_pkg::CFG_SIGN_ALLOWED: cfg_q.sign_allowed <= cfg_data_i[0];
        aip_pkg::CFG_MAX_CHARS:    cfg_q.max_chars    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{acc: '0, minus: 1'b0, cnt: '0, phase: aip_pkg::PH_IDLE,
                     radix: '0, digit_seen: 1'b0};
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q.status   <= status_d;
      out_q.value    <= state_d.acc;
      out_q.negative <= state_d.minus;
      out_q.consumed <= state_d.cnt;
    end
  end

endmodule

`default_nettype wire

// File: dv/ascii_integer_parser_tb.sv
// Self-checking testbench for the ASCII integer parser: directed and random character streams.
module ascii_integer_parser_tb;
  import aip_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TARGET_ITEMS = 950;
  localparam int QUIET_ITEMS  = 800;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic     clk         = 1'b0;
  logic     rst_n       = 1'b0;
  logic     in_valid    = 1'b0;
  logic     in_ready;
  aip_in_t  in_data     = '0;
  logic     out_valid;
  logic     out_ready   = 1'b0;
  aip_out_t out_data;
  logic     cfg_valid   = 1'b0;
  logic     cfg_ready;
  logic [1:0] cfg_index = CFG_RADIX_HINT;
  logic [7:0] cfg_data  = '0;

  // Mirror of the parser state and of its registers.
  logic [63:0] parse_value      = '0;
  logic        parse_minus      = 1'b0;
  logic [7:0]  parse_count      = '0;
  aip_phase_e  parse_step       = PH_IDLE;
  logic [5:0]  parse_radix      = '0;
  logic        parse_digit_seen = 1'b0;
  logic [5:0]  radix_hint_q     = RADIX_DEC;
  logic        sign_allowed_q   = 1'b1;
  logic [7:0]  max_chars_q      = '0;

  aip_out_t pending_results[$];

  int  errors            = 0;
  int  cycle_count       = 0;
  int  items_sent        = 0;
  int  numbers_started   = 0;
  int  registers_written = 0;
  int  status_seen[5]    = '{default: 0};
  bit  next_start        = 1'b0;
  bit  sender_gaps       = 1'b1;
  int  stall_pct         = 15;
  int  stall_left        = 0;

  ascii_integer_parser dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int char_to_digit(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
    if (c >= CH_LO_A && c <= CH_LO_Z) return int'(c) - int'(CH_LO_A) + 10;
    if (c >= CH_UP_A && c <= CH_UP_Z) return int'(c) - int'(CH_UP_A) + 10;
    return -1;
  endfunction

  function automatic void count_char();
    if (parse_count != COUNT_LIMIT) parse_count = parse_count + 8'd1;
  endfunction

  function automatic bit at_width_limit();
    return max_chars_q != 8'd0 && parse_count >= max_chars_q;
  endfunction

  function automatic aip_status_e abort_number();
    parse_value      = '0;
    parse_minus      = 1'b0;
    parse_count      = '0;
    parse_digit_seen = 1'b0;
    parse_step       = PH_IDLE;
    return ST_FAIL;
  endfunction

  function automatic aip_status_e take_digit(logic [7:0] c);
    int d;
    d = char_to_digit(c);
    if (d >= 0 && d < int'(parse_radix)) begin
      parse_value      = parse_value * 64'(parse_radix) + 64'(d);
      parse_digit_seen = 1'b1;
      count_char();
      if (at_width_limit()) begin
        parse_step = PH_IDLE;
        return ST_DONE_WIDTH;
      end
      return ST_MORE;
    end
    if (parse_digit_seen) begin
      parse_step = PH_IDLE;
      return ST_DONE_CHAR;
    end
    return abort_number();
  endfunction

  // A '0' that may open a 0x prefix is held until the next character decides.
  function automatic aip_status_e take_prefix(logic [7:0] c);
    if ((radix_hint_q == RADIX_AUTO || radix_hint_q == RADIX_HEX) && c == CH_ZERO &&
        (max_chars_q == 8'd0 || int'(parse_count) + 2 <= int'(max_chars_q))) begin
      count_char();
      parse_radix = (radix_hint_q == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
      parse_step  = PH_HELD;
      return ST_MORE;
    end
    if (radix_hint_q == RADIX_AUTO) begin
      parse_radix = (c == CH_ZERO) ? RADIX_OCT : RADIX_DEC;
    end else begin
      parse_radix = radix_hint_q;
    end
    parse_step = PH_DIGITS;
    return take_digit(c);
  endfunction

  function automatic aip_out_t parse_char(aip_in_t beat);
    aip_status_e st;
    aip_out_t    res;
    if (beat.start_req) begin
      parse_value      = '0;
      parse_minus      = 1'b0;
      parse_count      = '0;
      parse_radix      = '0;
      parse_digit_seen = 1'b0;
      parse_step       = PH_START;
    end
    case (parse_step)
      PH_START: begin
        if (radix_hint_q == RADIX_ONE || radix_hint_q > RADIX_MAX) begin
          st = abort_number();
        end else if (sign_allowed_q && (beat.ch == CH_PLUS || beat.ch == CH_MINUS)) begin
          parse_minus = (beat.ch == CH_MINUS);
          count_char();
          if (at_width_limit()) begin
            st = abort_number();
          end else begin
            parse_step = PH_PREFIX;
            st = ST_MORE;
          end
        end else begin
          st = take_prefix(beat.ch);
        end
      end
      PH_PREFIX: st = take_prefix(beat.ch);
      PH_HELD: begin
        if (beat.ch == CH_LO_X || beat.ch == CH_UP_X) begin
          count_char();
          parse_radix = RADIX_HEX;
          if (at_width_limit()) begin
            st = abort_number();
          end else begin
            parse_step = PH_DIGITS;
            st = ST_MORE;
          end
        end else begin
          // The held zero turns into a digit and this character follows it.
          parse_value      = '0;
          parse_digit_seen = 1'b1;
          parse_step       = PH_DIGITS;
          st = take_digit(beat.ch);
        end
      end
      PH_DIGITS: st = take_digit(beat.ch);
      default: begin
        st = ST_IDLE;
        parse_step = PH_IDLE;
      end
    endcase
    res.status   = st;
    res.value    = parse_value;
    res.negative = parse_minus;
    res.consumed = parse_count;
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Results are checked before new input beats are predicted within one edge.
  always @(posedge clk) begin : monitor
    aip_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d value %0h",
                   $time, out_data.status, out_data.value);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 64'(want.status), 64'(out_data.status));
          check_field("value", want.value, out_data.value);
          check_field("negative", 64'(want.negative), 64'(out_data.negative));
          check_field("consumed", 64'(want.consumed), 64'(out_data.consumed));
          if (out_data.status <= ST_IDLE) status_seen[out_data.status]++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RADIX_HINT:   radix_hint_q   = cfg_data[5:0];
          CFG_SIGN_ALLOWED: sign_allowed_q = cfg_data[0];
          CFG_MAX_CHARS:    max_chars_q    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) pending_results.push_back(parse_char(in_data));
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] ch);
    in_valid          <= 1'b1;
    in_data.ch        <= ch;
    in_data.start_req <= next_start;
    if (next_start) numbers_started++;
    next_start = 1'b0;
    items_sent++;
    do @(posedge clk); while (!in_ready);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    next_start = 1'b1;
    for (int i = 0; i < s.len(); i++) send_item(s[i]);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] data, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
    registers_written++;
  endtask

  // Holds the sender until every result is back and the pipeline has emptied.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] digit_char(int d);
    if (d < 10) return CH_ZERO + 8'(d);
    if ($urandom_range(0, 1)) return CH_LO_A + 8'(d - 10);
    return CH_UP_A + 8'(d - 10);
  endfunction

  function automatic logic [7:0] noise_char();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: return CH_ZERO;
      1: return CH_LO_X;
      2: return CH_UP_X;
      3: return CH_PLUS;
      4: return CH_MINUS;
      default: return 8'h00;
    endcase
  endfunction

  task automatic test_default_setup();
    next_start = 1'b0;
    send_item(CH_UP_A);
    send_text("-42");
    send_item(8'h00);
  endtask

  task automatic test_auto_radix();
    settle();
    write_register(CFG_RADIX_HINT, 8'(RADIX_AUTO), 1'b1);
    send_text("0X1f");
    send_item("g");
    send_text("0x");
    send_item("z");
    send_text("07");
    send_item("8");
  endtask

  task automatic test_radix_extremes();
    settle();
    // Upper data bits are outside the registers and must be dropped.
    write_register(CFG_RADIX_HINT, 8'h64, 1'b0);
    write_register(CFG_SIGN_ALLOWED, 8'hFE, 1'b1);
    send_text("+");
    send_text("Zz");
    send_item(8'h00);
  endtask

  task automatic test_width_limit();
    settle();
    write_register(CFG_RADIX_HINT, 8'd2, 1'b0);
    write_register(CFG_SIGN_ALLOWED, 8'h01, 1'b0);
    write_register(CFG_MAX_CHARS, 8'd3, 1'b1);
    send_text("-101");
    settle();
    write_register(CFG_RADIX_HINT, 8'(RADIX_AUTO), 1'b0);
    write_register(CFG_MAX_CHARS, 8'd1, 1'b1);
    send_text("-");
    send_text("0");
  endtask

  task automatic test_bad_radix();
    settle();
    write_register(CFG_RADIX_HINT, 8'(RADIX_ONE), 1'b1);
    send_text("5");
    settle();
    write_register(CFG_RADIX_HINT, 8'd37, 1'b0);
    write_register(CFG_UNUSED, 8'($urandom_range(0, 255)), 1'b1);
    send_text("5");
  endtask

  // Enough digits to wrap the value and saturate the consumed count.
  task automatic test_long_number();
    settle();
    write_register(CFG_RADIX_HINT, 8'(RADIX_MAX), 1'b0);
    write_register(CFG_SIGN_ALLOWED, 8'h00, 1'b0);
    write_register(CFG_MAX_CHARS, 8'd0, 1'b1);
    next_start = 1'b1;
    repeat (260) send_item(digit_char($urandom_range(0, 35)));
    send_item(8'h00);
  endtask

  task automatic random_number();
    int eff;
    int ndig;
    int style;
    next_start = 1'b1;
    if ($urandom_range(0, 9) < 7) begin
      if (sign_allowed_q && $urandom_range(0, 1)) begin
        send_item($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      end
      if (radix_hint_q == RADIX_AUTO) begin
        style = $urandom_range(0, 2);
        if (style == 0) begin
          send_item(CH_ZERO);
          send_item($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
          eff = 16;
        end else if (style == 1) begin
          send_item(CH_ZERO);
          eff = 8;
        end else begin
          eff = 10;
        end
      end else if (radix_hint_q == RADIX_HEX && $urandom_range(0, 2) == 0) begin
        send_item(CH_ZERO);
        send_item($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
        eff = 16;
      end else if (radix_hint_q >= 6'd2 && radix_hint_q <= RADIX_MAX) begin
        eff = int'(radix_hint_q);
      end else begin
        eff = 10;
      end
      ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 6);
      repeat (ndig) send_item(digit_char($urandom_range(0, eff - 1)));
      case ($urandom_range(0, 2))
        0: send_item(8'h00);
        1: send_item(8'h20);
        default: send_item(8'($urandom_range(0, 255)));
      endcase
    end else begin
      // Occasionally the noise continues whatever number is in progress.
      if ($urandom_range(0, 9) == 0) next_start = 1'b0;
      repeat ($urandom_range(1, 6)) send_item(noise_char());
    end
  endtask

  task automatic test_random_numbers();
    logic [5:0] radix;
    logic [7:0] width;
    while (items_sent < TARGET_ITEMS) begin
      settle();
      if ($urandom_range(0, 19) == 0) begin
        radix = ($urandom_range(0, 3) == 0) ? RADIX_ONE : 6'($urandom_range(37, 63));
      end else begin
        case ($urandom_range(0, 7))
          0, 1: radix = RADIX_AUTO;
          2: radix = RADIX_HEX;
          3: radix = RADIX_DEC;
          4: radix = RADIX_OCT;
          5: radix = 6'd2;
          6: radix = RADIX_MAX;
          default: radix = 6'($urandom_range(2, 36));
        endcase
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: width = 8'd0;
        5, 6, 7: width = 8'($urandom_range(1, 10));
        8: width = 8'($urandom_range(11, 254));
        default: width = 8'd255;
      endcase
      write_register(CFG_RADIX_HINT, {2'($urandom_range(0, 3)), radix}, 1'b0);
      write_register(CFG_SIGN_ALLOWED, 8'($urandom_range(0, 255)), 1'b0);
      write_register(CFG_MAX_CHARS, width, 1'b1);
      if (items_sent >= QUIET_ITEMS) begin
        sender_gaps = 1'b0;
        stall_pct   = 0;
      end else begin
        sender_gaps = $urandom_range(0, 3) != 0;
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 12;
          default: stall_pct = 35;
        endcase
      end
      if ($urandom_range(0, 3) == 0) send_item(noise_char());
      repeat ($urandom_range(5, 15)) random_number();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_setup();
    test_auto_radix();
    test_radix_extremes();
    test_width_limit();
    test_bad_radix();
    test_long_number();
    test_random_numbers();
    settle();
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("Sent %0d characters in %0d numbers with %0d register writes.",
             items_sent, numbers_started, registers_written);
    $display("Results seen: more %0d, done on char %0d, done on width %0d, failed %0d, idle %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
